>>> sv/mqttd_pkg.sv
// ---------------------------------------------------------------------------
// mqttd_pkg - shared types and constants of the PUBLISH stream deframer
// Parse phases, result kinds, the result word and field widths.
// ---------------------------------------------------------------------------
`default_nettype none

package mqttd_pkg;

	localparam int MAX_LENGTH_BYTES_DEF = 4;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 28;
	localparam int TLEN_W  = 16;
	localparam int FLAGS_W = 4;
	localparam int IDX_W   = 2;

	localparam logic [3:0] TYPE_PUBLISH = 4'h3;

	typedef enum logic [3:0] {
		PH_HDR     = 4'd0,
		PH_LEN     = 4'd1,
		PH_TLEN_HI = 4'd2,
		PH_TLEN_LO = 4'd3,
		PH_TOPIC   = 4'd4,
		PH_PID     = 4'd5,
		PH_MSG     = 4'd6,
		PH_SKIP    = 4'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TOPIC  = 2'd0,
		KIND_MSG    = 2'd1,
		KIND_END    = 2'd2,
		KIND_BADLEN = 2'd3
	} kind_t;

	typedef struct packed {
		logic              vld;
		logic [BYTE_W-1:0] data;
		kind_t             kind;
		logic              first;
		logic              last;
		logic [1:0]        qos;
	} res_t;

endpackage

`default_nettype wire

>>> sv/mqttd_parser.sv
// ---------------------------------------------------------------------------
// mqttd_parser - framing state and per-byte decode
// Holds the packet framing state and turns one byte into at most one result.
// ---------------------------------------------------------------------------
`default_nettype none

module mqttd_parser #(
	parameter int MAX_LENGTH_BYTES = mqttd_pkg::MAX_LENGTH_BYTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [mqttd_pkg::BYTE_W-1:0] rx_byte,
	output mqttd_pkg::res_t                  res
);

	localparam logic [mqttd_pkg::IDX_W-1:0] LastIdx =
		mqttd_pkg::IDX_W'(MAX_LENGTH_BYTES - 1);

	mqttd_pkg::phase_t                 phase_q, phase_d;
	logic [mqttd_pkg::FLAGS_W-1:0]     flags_q, flags_d;
	logic                              pub_q, pub_d;
	logic [mqttd_pkg::IDX_W-1:0]       idx_q, idx_d;
	logic [mqttd_pkg::LEN_W-1:0]       left_q, left_d;
	logic [mqttd_pkg::TLEN_W-1:0]      tlen_q, tlen_d;
	logic [mqttd_pkg::TLEN_W-1:0]      fleft_q, fleft_d;
	logic                              halt_q, halt_d;

	logic [mqttd_pkg::LEN_W-1:0]       left_dec;
	logic [mqttd_pkg::LEN_W-1:0]       len_add;
	logic [mqttd_pkg::LEN_W-1:0]       len_sum;
	logic [mqttd_pkg::TLEN_W-1:0]      tlen_full;
	logic [mqttd_pkg::TLEN_W-1:0]      fleft_dec;
	logic [mqttd_pkg::TLEN_W:0]        need;
	logic [1:0]                        qos;
	logic                              qos_nz;

	assign qos       = flags_q[2:1];
	assign qos_nz    = |qos;
	assign left_dec  = left_q - mqttd_pkg::LEN_W'(1);
	assign fleft_dec = fleft_q - mqttd_pkg::TLEN_W'(1);
	assign tlen_full = {tlen_q[15:8], rx_byte};
	assign need      = {1'b0, tlen_full} + {15'd0, qos_nz, 1'b0};
	assign len_sum   = left_q + len_add;

	always_comb begin
		case (idx_q)
			2'd0:    len_add = {21'd0, rx_byte[6:0]};
			2'd1:    len_add = {14'd0, rx_byte[6:0], 7'd0};
			2'd2:    len_add = {7'd0, rx_byte[6:0], 14'd0};
			default: len_add = {rx_byte[6:0], 21'd0};
		endcase
	end

	// next state and result for the byte in hand
	always_comb begin
		phase_d = phase_q;
		flags_d = flags_q;
		pub_d   = pub_q;
		idx_d   = idx_q;
		left_d  = left_q;
		tlen_d  = tlen_q;
		fleft_d = fleft_q;
		halt_d  = halt_q;
		res     = '{vld: 1'b0, data: '0, kind: mqttd_pkg::KIND_TOPIC,
			first: 1'b0, last: 1'b0, qos: qos};
		if (!halt_q) begin
			case (phase_q)
				mqttd_pkg::PH_HDR: begin
					flags_d = rx_byte[3:0];
					pub_d   = (rx_byte[7:4] == mqttd_pkg::TYPE_PUBLISH);
					idx_d   = '0;
					left_d  = '0;
					phase_d = mqttd_pkg::PH_LEN;
				end
				mqttd_pkg::PH_LEN: begin
					left_d = len_sum;
					if (rx_byte[7]) begin
						if (idx_q == LastIdx) begin
							halt_d   = 1'b1;
							res.vld  = 1'b1;
							res.kind = mqttd_pkg::KIND_BADLEN;
							res.qos  = 2'd0;
						end else begin
							idx_d = idx_q + mqttd_pkg::IDX_W'(1);
						end
					end else if (pub_q && (len_sum >= mqttd_pkg::LEN_W'(2))) begin
						phase_d = mqttd_pkg::PH_TLEN_HI;
					end else begin
						phase_d = (len_sum != '0) ? mqttd_pkg::PH_SKIP : mqttd_pkg::PH_HDR;
					end
				end
				mqttd_pkg::PH_TLEN_HI: begin
					tlen_d  = {rx_byte, 8'd0};
					left_d  = left_dec;
					phase_d = mqttd_pkg::PH_TLEN_LO;
				end
				mqttd_pkg::PH_TLEN_LO: begin
					tlen_d = tlen_full;
					left_d = left_dec;
					if (mqttd_pkg::LEN_W'(need) > left_dec) begin
						phase_d = (left_dec != '0) ? mqttd_pkg::PH_SKIP : mqttd_pkg::PH_HDR;
					end else if (tlen_full != '0) begin
						fleft_d = tlen_full;
						phase_d = mqttd_pkg::PH_TOPIC;
					end else if (qos_nz) begin
						fleft_d = mqttd_pkg::TLEN_W'(2);
						phase_d = mqttd_pkg::PH_PID;
					end else if (left_dec == '0) begin
						phase_d  = mqttd_pkg::PH_HDR;
						res.vld  = 1'b1;
						res.kind = mqttd_pkg::KIND_END;
						res.last = 1'b1;
					end else begin
						fleft_d = mqttd_pkg::TLEN_W'(1);
						phase_d = mqttd_pkg::PH_MSG;
					end
				end
				mqttd_pkg::PH_TOPIC: begin
					left_d    = left_dec;
					fleft_d   = fleft_dec;
					res.vld   = 1'b1;
					res.data  = rx_byte;
					res.kind  = mqttd_pkg::KIND_TOPIC;
					res.first = (fleft_q == tlen_q);
					if (fleft_dec == '0) begin
						if (qos_nz) begin
							fleft_d = mqttd_pkg::TLEN_W'(2);
							phase_d = mqttd_pkg::PH_PID;
						end else if (left_dec == '0) begin
							res.last = 1'b1;
							phase_d  = mqttd_pkg::PH_HDR;
						end else begin
							fleft_d = mqttd_pkg::TLEN_W'(1);
							phase_d = mqttd_pkg::PH_MSG;
						end
					end
				end
				mqttd_pkg::PH_PID: begin
					left_d  = left_dec;
					fleft_d = fleft_dec;
					if (fleft_dec == '0) begin
						if (left_dec == '0) begin
							phase_d  = mqttd_pkg::PH_HDR;
							res.vld  = 1'b1;
							res.kind = mqttd_pkg::KIND_END;
							res.last = 1'b1;
						end else begin
							fleft_d = mqttd_pkg::TLEN_W'(1);
							phase_d = mqttd_pkg::PH_MSG;
						end
					end
				end
				mqttd_pkg::PH_MSG: begin
					fleft_d   = '0;
					left_d    = left_dec;
					res.vld   = 1'b1;
					res.data  = rx_byte;
					res.kind  = mqttd_pkg::KIND_MSG;
					res.first = (fleft_q != '0);
					res.last  = (left_dec == '0);
					if (left_dec == '0) begin
						phase_d = mqttd_pkg::PH_HDR;
					end
				end
				mqttd_pkg::PH_SKIP: begin
					left_d = left_dec;
					if (left_dec == '0) begin
						phase_d = mqttd_pkg::PH_HDR;
					end
				end
				default: begin
					phase_d = mqttd_pkg::PH_HDR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mqttd_pkg::PH_HDR;
			flags_q <= '0;
			pub_q   <= 1'b0;
			idx_q   <= '0;
			left_q  <= '0;
			tlen_q  <= '0;
			fleft_q <= '0;
			halt_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			flags_q <= flags_d;
			pub_q   <= pub_d;
			idx_q   <= idx_d;
			left_q  <= left_d;
			tlen_q  <= tlen_d;
			fleft_q <= fleft_d;
			halt_q  <= halt_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/mqtt_publish_stream_deframer_core.sv
// A word is decoded from the input register and its result loaded into the result register.
// Throughput: one word per cycle while the output is not stalled; the parser
// updates its framing state in a single pass between the input and result registers.
// Stall on the output propagates to the input only while both registers hold.
// Reset (arst_n low, asynchronous) empties both registers and returns the
// parser to waiting for a header byte, also clearing a length-error halt.
// ---------------------------------------------------------------------------
// mqtt_publish_stream_deframer_core - PUBLISH deframer top level
// Splits an MQTT byte stream into topic and message words of PUBLISH packets, plus end and length-error markers.
// ---------------------------------------------------------------------------
`default_nettype none

module mqtt_publish_stream_deframer_core #(
	parameter int MAX_LENGTH_BYTES = mqttd_pkg::MAX_LENGTH_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      data_byte,
	output logic [1:0]      kind,
	output logic            first_of_field,
	output logic            last_of_publish,
	output logic [1:0]      qos_level
);

	logic                   vld_s1;
	logic [7:0]             byte_s1;
	logic                   out_vld_q;
	mqttd_pkg::res_t        res_q;
	mqttd_pkg::res_t        res;
	logic                   advance;
	logic                   step;
	logic                   accept;

	// The result register is free when empty or being taken this cycle
	assign advance  = !out_vld_q || !out_stall;
	// Decode the held word only when its result has somewhere to go
	assign step     = vld_s1 && advance;
	// Hold the input while the held word cannot move on
	assign in_stall = vld_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	mqttd_parser #(
		.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.rx_byte(byte_s1),
		.res    (res)
	);

	// Input register: advance when a new word arrives, drop once decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
		end
	end

	// Result register: when free, load a result if the decode made one, else empty out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= step && res.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.vld) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_vld_q;
	assign data_byte       = res_q.data;
	assign kind            = res_q.kind;
	assign first_of_field  = res_q.first;
	assign last_of_publish = res_q.last;
	assign qos_level       = res_q.qos;

endmodule

`default_nettype wire

>>> sv/mqttd_checker.sv
// ---------------------------------------------------------------------------
// mqttd_checker - port-level checks of the PUBLISH deframer
// Watches the output channel and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module mqttd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] data_byte,
	input wire logic [1:0] kind,
	input wire logic       first_of_field,
	input wire logic       last_of_publish,
	input wire logic [1:0] qos_level
);

	// a length error halts the block: nothing follows it
	a_halt_after_badlen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && kind == mqttd_pkg::KIND_BADLEN) |=> !out_valid)
		else $error("result after malformed length");

	a_badlen_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == mqttd_pkg::KIND_BADLEN) |->
		(data_byte == 8'd0 && qos_level == 2'd0 && !first_of_field && !last_of_publish))
		else $error("malformed length word not clean");

	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == mqttd_pkg::KIND_END) |->
		(last_of_publish && !first_of_field && data_byte == 8'd0))
		else $error("bad end marker");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(kind) && $stable(data_byte) && $stable(last_of_publish) &&
		 $stable(first_of_field) && $stable(qos_level)))
		else $error("stalled word changed");

	// only topic and message words open a field
	a_first_field: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && first_of_field) |->
		(kind == mqttd_pkg::KIND_TOPIC || kind == mqttd_pkg::KIND_MSG))
		else $error("first_of_field on a marker word");

endmodule

bind mqtt_publish_stream_deframer_core mqttd_checker u_mqttd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.data_byte      (data_byte),
	.kind           (kind),
	.first_of_field (first_of_field),
	.last_of_publish(last_of_publish),
	.qos_level      (qos_level)
);

`default_nettype wire
